// ----- hw/rtl/fba_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the frame bitmap allocator.
// No dependencies; imported by the allocator top level.
package fba_pkg;

   localparam int FRAME_W  = 12;     // frame field of a page entry
   localparam int CFG_W    = 13;     // frame_count register
   localparam int STATUS_W = 2;
   localparam int FIELD_FRAMES = 4096;  // reach of the 12-bit frame field

   localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 13'd4096;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTHING    = 2'd3;

endpackage

// ----- hw/rtl/frame_bitmap_allocator.sv -----
`timescale 1ns / 1ps
// Frame bitmap allocator top level: control FSM, bitmap RAM, word valid bits.
// Depends on fba_pkg, fba_ram and fba_zero_find.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------
//  request | req_mode/page_frame/kernel_page/writable | req_valid, req_stall
//  result  | rsp_new_frame/present/rw/user/status    | rsp_valid, rsp_stall
//  csr     | csr_frame_count                         | csr_valid, csr_ready
//
// One request at a time. Allocate with no frame: the scan examines one bitmap
// word per cycle (up to NWORDS words), set by the one-word-per-cycle RAM read.
// Free in range: ST_FREE_MUL/RD/WR, then ST_RESP; others go straight to ST_RESP.
// Reset clears the per-word valid bits at once; no clearing pass is needed.
// A new request is taken while an earlier result still waits in rsp_*.
module frame_bitmap_allocator #(
   parameter int MAX_FRAMES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [fba_pkg::FRAME_W-1:0]   req_page_frame,
   input  logic                          req_kernel_page,
   input  logic                          req_writable,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fba_pkg::FRAME_W-1:0]   rsp_new_frame,
   output logic                          rsp_present_bit,
   output logic                          rsp_rw_bit,
   output logic                          rsp_user_bit,
   output logic [fba_pkg::STATUS_W-1:0]  rsp_status,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fba_pkg::CFG_W-1:0]     csr_frame_count
);

   import fba_pkg::*;

   localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int DEPTH  = 1 << AW;
   localparam int OFF_W  = $clog2(WORD_BITS);
   localparam int BASE_W = CFG_W + 1;
   localparam int CAP    = (MAX_FRAMES < FIELD_FRAMES) ? MAX_FRAMES : FIELD_FRAMES;
   // exact reciprocal for frame / WORD_BITS over 12-bit frames
   localparam int SH     = FRAME_W + OFF_W;
   localparam int RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int PROD_W = (SH + AW > 2 * FRAME_W + 2) ? SH + AW : 2 * FRAME_W + 2;
   localparam logic [BASE_W-1:0] WORD_SPAN = BASE_W'(WORD_BITS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_FREE_MUL, ST_FREE_RD, ST_FREE_WR, ST_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       frame_count_ff, frame_count_in;
   logic [FRAME_W-1:0]     pf_ff, pf_in;
   logic                   kern_ff, kern_in;
   logic                   wr_ff, wr_in;
   logic [AW-1:0]          idx_ff, idx_in;
   logic [BASE_W-1:0]      base_ff, base_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [OFF_W-1:0]       off_ff, off_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic                   res_present_ff, res_present_in;
   logic                   res_rw_ff, res_rw_in;
   logic                   res_user_ff, res_user_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [FRAME_W-1:0]     rsp_frame_ff, rsp_frame_in;
   logic                   rsp_present_ff, rsp_present_in;
   logic                   rsp_rw_ff, rsp_rw_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   logic [DEPTH-1:0]       word_vld_ff;
   logic                   rd_vld_ff;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [WORD_BITS-1:0]   ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [WORD_BITS-1:0]   ram_rd_data;
   logic [WORD_BITS-1:0]   cur_word;
   logic                   zf_found;
   logic [OFF_W-1:0]       zf_idx;
   logic [CFG_W-1:0]       limit;
   logic [AW-1:0]          div_idx;
   logic                   req_take;
   logic                   rsp_load;

   fba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (DEPTH)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // a word never written since reset reads as all free
   assign cur_word = rd_vld_ff ? ram_rd_data : '0;

   fba_zero_find #(
      .WORD_BITS (WORD_BITS)
   ) u_zero_find (
      .word    (cur_word),
      .found   (zf_found),
      .bit_idx (zf_idx)
   );

   assign limit = (frame_count_ff > CFG_W'(CAP)) ? CFG_W'(CAP) : frame_count_ff;
   assign div_idx = prod_ff[SH +: AW];

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in       = state_ff;
      frame_count_in = frame_count_ff;
      pf_in          = pf_ff;
      kern_in        = kern_ff;
      wr_in          = wr_ff;
      idx_in         = idx_ff;
      base_in        = base_ff;
      prod_in        = prod_ff;
      off_in         = off_ff;
      res_frame_in   = res_frame_ff;
      res_present_in = res_present_ff;
      res_rw_in      = res_rw_ff;
      res_user_in    = res_user_ff;
      res_status_in  = res_status_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_ff;
      ram_wr_data    = '0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = idx_ff;

      if (csr_valid && csr_ready) begin
         frame_count_in = csr_frame_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               pf_in          = req_page_frame;
               kern_in        = req_kernel_page;
               wr_in          = req_writable;
               res_frame_in   = '0;
               res_present_in = 1'b0;
               res_rw_in      = 1'b0;
               res_user_in    = 1'b0;
               state_in       = ST_RESP;
               if (req_mode == MODE_ALLOC) begin
                  if (req_page_frame != '0) begin
                     res_frame_in  = req_page_frame;
                     res_status_in = STATUS_ALREADY;
                  end else begin
                     idx_in      = '0;
                     base_in     = '0;
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = ST_SCAN;
                  end
               end else if (req_page_frame == '0) begin
                  res_status_in = STATUS_NOTHING;
               end else begin
                  res_status_in = STATUS_DONE;
                  // frames beyond the bitmap are ignored
                  if (32'(req_page_frame) < 32'(MAX_FRAMES)) begin
                     state_in = ST_FREE_MUL;
                  end
               end
            end
         end
         ST_SCAN: begin
            if ((base_ff + WORD_SPAN) > BASE_W'(limit)) begin
               res_status_in = STATUS_NO_FREE;
               state_in      = ST_RESP;
            end else if (!zf_found) begin
               idx_in      = idx_ff + AW'(1);
               base_in     = base_ff + WORD_SPAN;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + AW'(1);
            end else begin
               ram_wr_en      = 1'b1;
               ram_wr_addr    = idx_ff;
               ram_wr_data    = cur_word | (WORD_BITS'(1) << zf_idx);
               res_frame_in   = FRAME_W'(base_ff + BASE_W'(zf_idx));
               res_present_in = 1'b1;
               res_rw_in      = wr_ff;
               res_user_in    = ~kern_ff;
               res_status_in  = STATUS_DONE;
               state_in       = ST_RESP;
            end
         end
         ST_FREE_MUL: begin
            prod_in  = PROD_W'(pf_ff) * PROD_W'(RECIP);
            state_in = ST_FREE_RD;
         end
         ST_FREE_RD: begin
            idx_in      = div_idx;
            off_in      = OFF_W'(pf_ff - FRAME_W'(div_idx) * FRAME_W'(WORD_BITS));
            ram_rd_en   = 1'b1;
            ram_rd_addr = div_idx;
            state_in    = ST_FREE_WR;
         end
         ST_FREE_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = cur_word & ~(WORD_BITS'(1) << off_ff);
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register: holds a finished result while the next request runs
   always_comb begin
      rsp_frame_in   = rsp_frame_ff;
      rsp_present_in = rsp_present_ff;
      rsp_rw_in      = rsp_rw_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_frame_in   = res_frame_ff;
         rsp_present_in = res_present_ff;
         rsp_rw_in      = res_rw_ff;
         rsp_user_in    = res_user_ff;
         rsp_status_in  = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= FRAME_COUNT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      pf_ff          <= pf_in;
      kern_ff        <= kern_in;
      wr_ff          <= wr_in;
      idx_ff         <= idx_in;
      base_ff        <= base_in;
      prod_ff        <= prod_in;
      off_ff         <= off_in;
      res_frame_ff   <= res_frame_in;
      res_present_ff <= res_present_in;
      res_rw_ff      <= res_rw_in;
      res_user_ff    <= res_user_in;
      res_status_ff  <= res_status_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_present_ff <= rsp_present_in;
      rsp_rw_ff      <= rsp_rw_in;
      rsp_user_ff    <= rsp_user_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // per-word written flags; read alongside the RAM data
   always_ff @(posedge clock) begin
      if (reset) begin
         word_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         if (ram_wr_en) begin
            word_vld_ff[ram_wr_addr] <= 1'b1;
         end
         if (ram_rd_en) begin
            rd_vld_ff <= word_vld_ff[ram_rd_addr];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_frame   = rsp_frame_ff;
   assign rsp_present_bit = rsp_present_ff;
   assign rsp_rw_bit      = rsp_rw_ff;
   assign rsp_user_bit    = rsp_user_ff;
   assign rsp_status      = rsp_status_ff;

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result appeared without a finished request");

   a_present_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_present_ff |-> rsp_status_ff == STATUS_DONE)
      else $error("present bit with non-done status");

   a_scan_in_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> base_ff <= BASE_W'(limit))
      else $error("scan ran past the frame limit");

   a_word_marked: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> word_vld_ff[$past(ram_wr_addr)])
      else $error("written word not marked valid");

endmodule

// ----- hw/rtl/fba_ram.sv -----
`timescale 1ns / 1ps
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module fba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/fba_zero_find.sv -----
`timescale 1ns / 1ps
// Lowest-clear-bit finder for one bitmap word.
// No dependencies; used by the allocator top level.
module fba_zero_find #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]         word,
   output logic                         found,
   output logic [$clog2(WORD_BITS)-1:0] bit_idx
);

   localparam int BW = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] lowest_zero;

   // ~w & (w + 1) isolates the lowest clear bit; zero when the word is full
   assign lowest_zero = ~word & (word + WORD_BITS'(1));
   assign found = |lowest_zero;

   always_comb begin
      bit_idx = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         if (lowest_zero[k]) begin
            bit_idx = bit_idx | BW'(k);
         end
      end
   end

endmodule
